// ----- design/mtas_pkg.sv -----
// shared types and constants of the mesh triangle adjacency search
`timescale 1ns / 1ps

package mtas_pkg;

	// fixed field widths at the ports
	localparam int VERTEX_W = 12;
	localparam int INDEX_W  = 11;
	localparam int COUNT_W  = 12;

	// action codes of an input word
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// controller to datapath commands
	typedef struct packed {
		logic write;   // store one triangle this cycle
		logic start;   // load query, clear scan state
		logic scan;    // issue table reads
		logic finish;  // emit the closing result word
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic scan_done;   // every entry up to the limit has been read
		logic pipe_empty;  // no read waits for its compare
		logic out_free;    // output register can take a word this cycle
	} sts_t;

endpackage

// ----- design/mtas_ram.sv -----
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module mtas_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data holds while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/mtas_ctrl.sv -----
// controller state machine of the triangle adjacency search
`timescale 1ns / 1ps

module mtas_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           action,
	output logic           in_ready,
	output mtas_pkg::cmd_t cmd,
	input  mtas_pkg::sts_t sts
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   accept;

	assign accept = in_valid && ready_q;

	// commands
	always_comb begin
		cmd        = '0;
		cmd.write  = accept && (action == mtas_pkg::ACT_WRITE);
		cmd.start  = accept && (action == mtas_pkg::ACT_QUERY);
		cmd.scan   = (state_q == ST_SCAN);
		cmd.finish = (state_q == ST_FINISH);
	end

	// state and registered ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					ready_q <= 1'b1;
					if (accept && (action == mtas_pkg::ACT_QUERY)) begin
						state_q <= ST_SCAN;
						ready_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (sts.scan_done && sts.pipe_empty) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b0;
				end
			endcase
		end
	end

	assign in_ready = ready_q;

endmodule

// ----- design/mtas_dp.sv -----
// datapath: triangle table, scan counter, match compare, pending and output words
`timescale 1ns / 1ps

module mtas_dp #(
	parameter int MAX_TRIANGLES = 2048,
	parameter int VERTEX_BITS   = 12,
	parameter int MAX_MATCHES   = 6
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mtas_pkg::cmd_t                 cmd,
	output mtas_pkg::sts_t                 sts,
	input  logic                           cfg_valid,
	input  logic [mtas_pkg::COUNT_W-1:0]   cfg_data,
	input  logic [mtas_pkg::INDEX_W-1:0]   entry_index,
	input  logic [mtas_pkg::VERTEX_W-1:0]  write_vertex_0,
	input  logic [mtas_pkg::VERTEX_W-1:0]  write_vertex_1,
	input  logic [mtas_pkg::VERTEX_W-1:0]  write_vertex_2,
	input  logic [mtas_pkg::VERTEX_W-1:0]  query_vertex_a,
	input  logic [mtas_pkg::VERTEX_W-1:0]  query_vertex_b,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic                           found,
	output logic [mtas_pkg::VERTEX_W-1:0]  corner_0,
	output logic [mtas_pkg::VERTEX_W-1:0]  corner_1,
	output logic [mtas_pkg::VERTEX_W-1:0]  corner_2,
	output logic                           last,
	output logic                           overflow
);

	localparam int AW = $clog2(MAX_TRIANGLES);
	localparam int CW = $clog2(MAX_TRIANGLES + 1);
	localparam int NW = $clog2(MAX_MATCHES + 1);
	localparam int VB = VERTEX_BITS;
	localparam int OW = mtas_pkg::VERTEX_W;

	logic [mtas_pkg::COUNT_W-1:0] tri_count_q;
	logic [CW-1:0]                addr_q;
	logic [CW-1:0]                limit_q;
	logic [VB-1:0]                qa_q;
	logic [VB-1:0]                qb_q;
	logic                         rd_valid_s1;
	logic [NW-1:0]                n_q;
	logic                         ovf_q;
	logic                         pend_valid_q;
	logic [VB-1:0]                pend_c0_q;
	logic [VB-1:0]                pend_c1_q;
	logic [VB-1:0]                pend_c2_q;
	logic                         out_valid_q;
	logic                         found_q;
	logic [OW-1:0]                c0_q;
	logic [OW-1:0]                c1_q;
	logic [OW-1:0]                c2_q;
	logic                         last_q;
	logic                         ovf_out_q;

	logic                         we;
	logic [3*VB-1:0]              rdata;
	logic [VB-1:0]                rc0;
	logic [VB-1:0]                rc1;
	logic [VB-1:0]                rc2;
	logic                         has_a;
	logic                         has_b;
	logic                         hit;
	logic                         room;
	logic                         out_free;
	logic                         push_pend;
	logic                         stall;
	logic                         issue;
	logic                         finish_go;

	// table memory, writes beyond the table are dropped
	assign we = cmd.write && (32'(entry_index) < 32'(MAX_TRIANGLES));

	mtas_ram #(
		.WIDTH (3 * VB),
		.DEPTH (MAX_TRIANGLES)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (AW'(entry_index)),
		.wdata ({VB'(write_vertex_2), VB'(write_vertex_1), VB'(write_vertex_0)}),
		.re    (issue),
		.raddr (addr_q[AW-1:0]),
		.rdata (rdata)
	);

	// match compare on the word just read
	assign rc0   = rdata[VB-1:0];
	assign rc1   = rdata[2*VB-1:VB];
	assign rc2   = rdata[3*VB-1:2*VB];
	assign has_a = (rc0 == qa_q) || (rc1 == qa_q) || (rc2 == qa_q);
	assign has_b = (rc0 == qb_q) || (rc1 == qb_q) || (rc2 == qb_q);
	// with a equal to b both terms are the same, so one product covers both query kinds
	assign hit   = rd_valid_s1 && has_a && has_b;
	assign room  = (n_q < NW'(MAX_MATCHES));

	// a new match pushes the held one out, since only the final word gets last
	assign out_free  = !out_valid_q || out_ready;
	assign push_pend = hit && room && pend_valid_q;
	assign stall     = push_pend && !out_free;
	assign issue     = cmd.scan && (addr_q != limit_q) && !stall;
	assign finish_go = cmd.finish && out_free;

	assign sts.scan_done  = (addr_q == limit_q);
	assign sts.pipe_empty = !rd_valid_s1;
	assign sts.out_free   = out_free;

	// configuration register and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tri_count_q  <= '0;
			addr_q       <= '0;
			limit_q      <= '0;
			rd_valid_s1  <= 1'b0;
			n_q          <= '0;
			ovf_q        <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				tri_count_q <= cfg_data;
			end
			if (cmd.start) begin
				addr_q       <= '0;
				n_q          <= '0;
				ovf_q        <= 1'b0;
				pend_valid_q <= 1'b0;
				rd_valid_s1  <= 1'b0;
				if (32'(tri_count_q) > 32'(MAX_TRIANGLES)) begin
					limit_q <= CW'(MAX_TRIANGLES);
				end else begin
					limit_q <= CW'(tri_count_q);
				end
			end else if (finish_go) begin
				pend_valid_q <= 1'b0;
			end else if (!stall) begin
				rd_valid_s1 <= issue;
				if (issue) begin
					addr_q <= addr_q + CW'(1);
				end
				if (hit && room) begin
					n_q          <= n_q + NW'(1);
					pend_valid_q <= 1'b1;
				end else if (hit) begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	// query vertices and held match
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			qa_q <= VB'(query_vertex_a);
			qb_q <= VB'(query_vertex_b);
		end
		if (hit && room && !stall) begin
			pend_c0_q <= rc0;
			pend_c1_q <= rc1;
			pend_c2_q <= rc2;
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((push_pend && out_free) || finish_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (push_pend && out_free) begin
			found_q   <= 1'b1;
			c0_q      <= OW'(pend_c0_q);
			c1_q      <= OW'(pend_c1_q);
			c2_q      <= OW'(pend_c2_q);
			last_q    <= 1'b0;
			ovf_out_q <= 1'b0;
		end else if (finish_go) begin
			found_q   <= pend_valid_q;
			c0_q      <= pend_valid_q ? OW'(pend_c0_q) : '0;
			c1_q      <= pend_valid_q ? OW'(pend_c1_q) : '0;
			c2_q      <= pend_valid_q ? OW'(pend_c2_q) : '0;
			last_q    <= 1'b1;
			ovf_out_q <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign corner_0  = c0_q;
	assign corner_1  = c1_q;
	assign corner_2  = c2_q;
	assign last      = last_q;
	assign overflow  = ovf_out_q;

	// scan never runs past its limit
	a_addr_limit: assert property (@(posedge clk) disable iff (!arst_n)
		addr_q <= limit_q)
		else $error("scan address beyond limit");

	// match count bounded by the result budget
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= NW'(MAX_MATCHES))
		else $error("match count beyond budget");

	// overflow only once the budget is used up
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (n_q == NW'(MAX_MATCHES)))
		else $error("overflow before budget is full");

	// a held match always counts
	a_pend_count: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> (n_q != '0))
		else $error("held match with zero count");

endmodule

// ----- design/mesh_triangle_adjacency_search.sv -----
// top level of the mesh triangle adjacency search
`timescale 1ns / 1ps

// Triangle table with vertex query. A write word (action 0) stores one
// triangle. A query word (action 1) scans entries 0 up to
// min(triangle_count, MAX_TRIANGLES) - 1, one entry per cycle through the
// single read port of the table memory, except while a new match waits for
// the output side. A query holds the block from its accept to the next
// accept: one read per entry, the last compare, entry to the closing state
// and the sending of the closing word, plus any wait for the output side to
// free up for a new match or the closing word.
// Each of the first MAX_MATCHES matching triangles comes out as one word with
// found set; the final word of a query carries last, and overflow when more
// than MAX_MATCHES triangles matched. A query with no match gives one word
// with found clear. Entries read by a query must have been written since reset.
// triangle_count must be written only while the block is idle; the block
// itself does not enforce this.

module mesh_triangle_adjacency_search #(
	parameter int MAX_TRIANGLES = 2048,
	parameter int VERTEX_BITS   = 12,
	parameter int MAX_MATCHES   = 6
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mtas_pkg::COUNT_W-1:0]   cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           action,
	input  logic [mtas_pkg::INDEX_W-1:0]   entry_index,
	input  logic [mtas_pkg::VERTEX_W-1:0]  write_vertex_0,
	input  logic [mtas_pkg::VERTEX_W-1:0]  write_vertex_1,
	input  logic [mtas_pkg::VERTEX_W-1:0]  write_vertex_2,
	input  logic [mtas_pkg::VERTEX_W-1:0]  query_vertex_a,
	input  logic [mtas_pkg::VERTEX_W-1:0]  query_vertex_b,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           found,
	output logic [mtas_pkg::VERTEX_W-1:0]  corner_0,
	output logic [mtas_pkg::VERTEX_W-1:0]  corner_1,
	output logic [mtas_pkg::VERTEX_W-1:0]  corner_2,
	output logic                           last,
	output logic                           overflow
);

	mtas_pkg::cmd_t cmd;
	mtas_pkg::sts_t sts;

	// configuration is always taken
	assign cfg_ready = 1'b1;

	mtas_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (action),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	mtas_dp #(
		.MAX_TRIANGLES (MAX_TRIANGLES),
		.VERTEX_BITS   (VERTEX_BITS),
		.MAX_MATCHES   (MAX_MATCHES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_valid      (cfg_valid),
		.cfg_data       (cfg_data),
		.entry_index    (entry_index),
		.write_vertex_0 (write_vertex_0),
		.write_vertex_1 (write_vertex_1),
		.write_vertex_2 (write_vertex_2),
		.query_vertex_a (query_vertex_a),
		.query_vertex_b (query_vertex_b),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.found          (found),
		.corner_0       (corner_0),
		.corner_1       (corner_1),
		.corner_2       (corner_2),
		.last           (last),
		.overflow       (overflow)
	);

endmodule

// ----- bench/mesh_triangle_adjacency_search_tb.sv -----
// self-checking testbench of the mesh triangle adjacency search
`timescale 1ns / 1ps

module mesh_triangle_adjacency_search_tb;

	localparam int TABLE_DEPTH   = 2048;
	localparam int FILL_ENTRIES  = 64;
	localparam int MATCH_LIMIT   = 6;
	localparam int GAP_MAX       = 15;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 400;
	localparam int DRAIN_CYCLES  = 2100;
	localparam int PHASE_WORDS   = 20;

	typedef logic [mtas_pkg::VERTEX_W-1:0] vtx_t;
	typedef logic [mtas_pkg::INDEX_W-1:0]  idx_t;
	typedef logic [mtas_pkg::COUNT_W-1:0]  cnt_t;

	typedef enum logic [1:0] {STEP_WORD, STEP_CFG, STEP_DRAIN, STEP_HOLD} step_kind_t;

	// one entry of the stimulus plan
	typedef struct {
		step_kind_t kind;
		logic       act;
		idx_t       idx;
		vtx_t       v0, v1, v2, qa, qb;
		cnt_t       count;
	} step_t;

	// one result word as the block should send it
	typedef struct packed {
		logic found;
		vtx_t c0, c1, c2;
		logic last;
		logic ovf;
	} match_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cnt_t cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic action = mtas_pkg::ACT_WRITE;
	idx_t entry_index = '0;
	vtx_t write_vertex_0 = '0;
	vtx_t write_vertex_1 = '0;
	vtx_t write_vertex_2 = '0;
	vtx_t query_vertex_a = '0;
	vtx_t query_vertex_b = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic found;
	vtx_t corner_0, corner_1, corner_2;
	logic last;
	logic overflow;

	// local copy of the triangle table and the count register
	vtx_t tri_table [0:TABLE_DEPTH-1][0:2];
	cnt_t tri_count = '0;

	match_t match_words_due [$];
	step_t word_plan [$];

	int fails = 0;
	int send_gap = 0;
	bit send_burst = 1'b0;
	int recv_gap = 0;
	bit recv_burst = 1'b0;
	int quiet = 0;
	logic hold_req = 1'b0;
	int hold_left = 0;

	mesh_triangle_adjacency_search dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.action         (action),
		.entry_index    (entry_index),
		.write_vertex_0 (write_vertex_0),
		.write_vertex_1 (write_vertex_1),
		.write_vertex_2 (write_vertex_2),
		.query_vertex_a (query_vertex_a),
		.query_vertex_b (query_vertex_b),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.found          (found),
		.corner_0       (corner_0),
		.corner_1       (corner_1),
		.corner_2       (corner_2),
		.last           (last),
		.overflow       (overflow)
	);

	// clock and reset
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic bit holds_vertex(int e, vtx_t v);
		return tri_table[e][0] == v || tri_table[e][1] == v || tri_table[e][2] == v;
	endfunction

	// scan the table copy in order and queue the words a query should give
	task automatic search_table(input vtx_t va, input vtx_t vb);
		int lim;
		int n;
		int e;
		bit hit;
		bit ovf;
		match_t m;
		lim = (tri_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(tri_count);
		n = 0;
		ovf = 1'b0;
		m = '0;
		for (e = 0; e < lim; e++) begin
			if (va == vb)
				hit = holds_vertex(e, va);
			else
				hit = holds_vertex(e, va) && holds_vertex(e, vb);
			if (hit) begin
				if (n < MATCH_LIMIT) begin
					// previous match is not the final one
					if (n > 0)
						match_words_due.push_back(m);
					m = '0;
					m.found = 1'b1;
					m.c0 = tri_table[e][0];
					m.c1 = tri_table[e][1];
					m.c2 = tri_table[e][2];
					n++;
				end else begin
					ovf = 1'b1;
				end
			end
		end
		// final word carries last, and overflow if matches were dropped
		m.last = 1'b1;
		m.ovf = ovf;
		match_words_due.push_back(m);
	endtask

	function automatic void compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s expected %0d got %0d", name, want, got);
			fails++;
		end
	endfunction

	function automatic vtx_t pick_vertex();
		// mostly a small pool so that triangles share vertices
		if ($urandom_range(0, 9) == 0)
			return vtx_t'($urandom_range(0, 2**mtas_pkg::VERTEX_W - 1));
		return vtx_t'($urandom_range(0, 15));
	endfunction

	task automatic add_write(input int e, input vtx_t a, input vtx_t b, input vtx_t c);
		step_t s;
		s.kind = STEP_WORD;
		s.act = mtas_pkg::ACT_WRITE;
		s.idx = idx_t'(e);
		s.v0 = a;
		s.v1 = b;
		s.v2 = c;
		s.qa = vtx_t'($urandom);
		s.qb = vtx_t'($urandom);
		s.count = '0;
		word_plan.push_back(s);
	endtask

	task automatic add_query(input vtx_t a, input vtx_t b);
		step_t s;
		s.kind = STEP_WORD;
		s.act = mtas_pkg::ACT_QUERY;
		s.idx = idx_t'($urandom);
		s.v0 = vtx_t'($urandom);
		s.v1 = vtx_t'($urandom);
		s.v2 = vtx_t'($urandom);
		s.qa = a;
		s.qb = b;
		s.count = '0;
		word_plan.push_back(s);
	endtask

	task automatic add_step(input step_kind_t k, input cnt_t n);
		step_t s;
		s.kind = k;
		s.act = mtas_pkg::ACT_WRITE;
		s.idx = '0;
		s.v0 = '0;
		s.v1 = '0;
		s.v2 = '0;
		s.qa = '0;
		s.qb = '0;
		s.count = n;
		word_plan.push_back(s);
	endtask

	// stimulus plan
	initial begin : build_plan
		int p;
		int k;
		int n;
		int e;
		vtx_t va;
		// count is zero out of reset, so this query scans nothing
		add_query(12'd5, 12'd5);
		// load the low entries so that every count used reads written data
		for (e = 0; e < FILL_ENTRIES; e++)
			add_write(e, pick_vertex(), pick_vertex(), pick_vertex());

		// directed: known triangles around vertex 5 and the field extremes
		add_write(0, 12'd5, 12'd6, 12'd7);
		add_write(1, 12'd0, 12'hFFF, 12'd5);
		add_write(2, 12'hFFF, 12'hAAA, 12'h555);
		add_write(3, 12'd5, 12'd5, 12'd5);
		add_write(4, 12'd6, 12'd5, 12'd9);
		add_write(5, 12'd5, 12'd7, 12'd6);
		add_write(6, 12'd5, 12'd8, 12'd10);
		add_write(7, 12'd5, 12'd11, 12'd12);
		add_write(8, 12'd5, 12'd13, 12'd6);
		add_step(STEP_CFG, 12'd9);
		add_query(12'd5, 12'd5);
		add_query(12'd5, 12'd6);
		add_query(12'hFFF, 12'd0);
		add_query(12'hAAA, 12'hAAA);
		add_query(12'hFFF, 12'hFFF);
		add_query(12'd7, 12'd9);
		add_query(12'h555, 12'hFFF);
		// exactly the match limit, then one past it
		add_step(STEP_CFG, 12'd7);
		add_query(12'd5, 12'd5);
		add_step(STEP_CFG, 12'd8);
		add_query(12'd5, 12'd5);
		add_step(STEP_CFG, 12'd1);
		add_query(12'd6, 12'd7);
		add_step(STEP_CFG, 12'd0);
		add_query(12'd5, 12'd5);
		// every loaded entry
		add_step(STEP_CFG, cnt_t'(FILL_ENTRIES));
		add_query(12'd5, 12'd5);
		add_query(12'd3, 12'd9);

		// random phases, mostly small counts
		for (p = 0; p < 10; p++) begin
			case (p)
				3: begin
					n = FILL_ENTRIES;
				end
				6: begin
					n = FILL_ENTRIES - 1;
				end
				default: begin
					n = $urandom_range(1, 48);
				end
			endcase
			add_step(STEP_CFG, cnt_t'(n));
			for (k = 0; k < PHASE_WORDS; k++) begin
				if (p == 2 && k == 4)
					add_step(STEP_HOLD, '0);
				if (p == 1 && k == 17)
					add_step(STEP_DRAIN, '0);
				if ($urandom_range(0, 9) < 4) begin
					if ($urandom_range(0, 19) < 17)
						e = $urandom_range(0, FILL_ENTRIES - 1);
					else
						e = $urandom_range(0, TABLE_DEPTH - 1);
					add_write(e, pick_vertex(), pick_vertex(), pick_vertex());
				end else begin
					va = pick_vertex();
					add_query(va, ($urandom_range(0, 2) == 0) ? va : pick_vertex());
				end
			end
		end
	end

	// driver: input words and register writes from the plan
	always @(posedge clk or negedge arst_n) begin : driver
		logic nv;
		logic ncv;
		logic nh;
		step_t s;
		if (!arst_n) begin
			in_valid <= 1'b0;
			cfg_valid <= 1'b0;
			hold_req <= 1'b0;
		end else begin
			nv = in_valid;
			ncv = cfg_valid;
			nh = 1'b0;
			// word taken: update the table copy or predict the query
			if (in_valid && in_ready) begin
				if (action == mtas_pkg::ACT_WRITE) begin
					tri_table[entry_index][0] = write_vertex_0;
					tri_table[entry_index][1] = write_vertex_1;
					tri_table[entry_index][2] = write_vertex_2;
				end else begin
					search_table(query_vertex_a, query_vertex_b);
				end
				nv = 1'b0;
				send_gap = send_burst ? 0 : $urandom_range(0, GAP_MAX);
				if ($urandom_range(0, 39) == 0)
					send_burst = !send_burst;
			end
			if (cfg_valid && cfg_ready) begin
				tri_count = cfg_data;
				ncv = 1'b0;
			end
			// cycles with nothing in flight
			if (match_words_due.size() == 0 && !in_valid && !cfg_valid)
				quiet++;
			else
				quiet = 0;
			if (!nv && !ncv && word_plan.size() != 0) begin
				s = word_plan[0];
				case (s.kind)
					STEP_WORD: begin
						if (send_gap != 0) begin
							send_gap--;
						end else begin
							action <= s.act;
							entry_index <= s.idx;
							write_vertex_0 <= s.v0;
							write_vertex_1 <= s.v1;
							write_vertex_2 <= s.v2;
							query_vertex_a <= s.qa;
							query_vertex_b <= s.qb;
							nv = 1'b1;
							void'(word_plan.pop_front());
						end
					end
					STEP_CFG: begin
						if (quiet >= SETTLE_CYCLES) begin
							cfg_data <= s.count;
							ncv = 1'b1;
							void'(word_plan.pop_front());
						end
					end
					STEP_DRAIN: begin
						if (quiet >= SETTLE_CYCLES)
							void'(word_plan.pop_front());
					end
					STEP_HOLD: begin
						nh = 1'b1;
						void'(word_plan.pop_front());
					end
					default: begin
						void'(word_plan.pop_front());
					end
				endcase
			end
			in_valid <= nv;
			cfg_valid <= ncv;
			hold_req <= nh;
		end
	end

	// long receiver hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_req)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// monitor: take result words and compare with the oldest expectation
	always @(posedge clk or negedge arst_n) begin : monitor
		logic nr;
		match_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			nr = out_ready;
			if (out_valid && out_ready) begin
				if (match_words_due.size() == 0) begin
					$error("result word with no expectation waiting");
					fails++;
				end else begin
					want = match_words_due.pop_front();
					compare_field("found", want.found, found);
					compare_field("corner_0", want.c0, corner_0);
					compare_field("corner_1", want.c1, corner_1);
					compare_field("corner_2", want.c2, corner_2);
					compare_field("last", want.last, last);
					compare_field("overflow", want.ovf, overflow);
				end
				nr = 1'b0;
				recv_gap = recv_burst ? 0 : $urandom_range(0, GAP_MAX);
				if ($urandom_range(0, 39) == 0)
					recv_burst = !recv_burst;
			end
			if (hold_left != 0) begin
				nr = 1'b0;
			end else if (!nr) begin
				if (recv_gap != 0)
					recv_gap--;
				else
					nr = 1'b1;
			end
			out_ready <= nr;
		end
	end

	// end of run
	initial begin : finish_run
		@(posedge arst_n);
		do
			@(negedge clk);
		while (word_plan.size() != 0 || in_valid || cfg_valid || match_words_due.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (match_words_due.size() != 0) begin
			$error("%0d expected words never arrived", match_words_due.size());
			fails++;
		end
		if (fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// timeout
	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
design/mtas_pkg.sv
design/mtas_ram.sv
design/mtas_ctrl.sv
design/mtas_dp.sv
design/mesh_triangle_adjacency_search.sv
bench/mesh_triangle_adjacency_search_tb.sv
